// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// shared types and constants of the critically damped smoother
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned STEP_W = 16;
   localparam int unsigned CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTH_TIME = 1'b0,
      CSR_MAX_SPEED   = 1'b1
   } csr_index_type;

   localparam logic [STEP_W-1:0] STEP_MIN = 16'd66;

   // per-item values common to both axis lanes
   typedef struct packed {
      logic signed [WORD_W-1:0] omega;
      logic signed [WORD_W-1:0] decay;
      logic signed [WORD_W-1:0] dt;
      logic signed [WORD_W-1:0] limit;
   } coef_type;

   // saturate a 66-bit signed value to 32 bits
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      begin
         hi = 66'sh7FFFFFFF;
         lo = -66'sh80000000;
         if (v > hi) sat32 = 32'sh7FFFFFFF;
         else if (v < lo) sat32 = 32'sh80000000;
         else sat32 = v[WORD_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/cds_if.sv =====
// ----------------------------------------------------------------------------
// cds_req_if / cds_rsp_if / cds_csr_if
// valid/ready channels of the smoother
// ----------------------------------------------------------------------------
interface cds_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] current_x;
   logic signed [31:0] current_y;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic [15:0] step_time;
   modport source (output valid, current_x, current_y, target_x, target_y, step_time,
                   input ready);
   modport sink (input valid, current_x, current_y, target_x, target_y, step_time,
                 output ready);
endinterface

interface cds_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] result_x;
   logic signed [31:0] result_y;
   logic signed [31:0] speed_x;
   logic signed [31:0] speed_y;
   modport source (output valid, result_x, result_y, speed_x, speed_y, input ready);
   modport sink (input valid, result_x, result_y, speed_x, speed_y, output ready);
endinterface

interface cds_csr_if;
   logic valid;
   logic ready;
   logic [31:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/cds_divider.sv =====
// ----------------------------------------------------------------------------
// cds_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cds_divider #(
   parameter int unsigned NUM_W = 56,
   parameter int unsigned DEN_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[NUM_W-1]} - {2'b00, d_ff};
      if (start) begin
         q_in = numer;
         r_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            r_in = trial[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= denom;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== hdl/cds_lane.sv =====
// ----------------------------------------------------------------------------
// cds_lane
// one axis of the smoothing step, sequenced over a single multiplier
// ----------------------------------------------------------------------------
module cds_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  cds_pkg::coef_type        coef,
   input  logic signed [31:0]       cur,
   input  logic signed [31:0]       tgt,
   input  logic signed [31:0]       vel,
   output logic                     done,
   output logic signed [31:0]       res,
   output logic signed [31:0]       new_vel
);
   import cds_pkg::*;

   // ordered products: omega*change, (v+.)*dt, omega*temp, (v-.)*e, (change+temp)*e
   typedef enum logic [2:0] {P0, P1, P2, P3, P4, PD} pstep_type;

   pstep_type ps_ff;
   logic busy_ff;
   logic fin_ff;
   logic signed [31:0] change_ff;
   logic signed [31:0] vel_ff;
   logic signed [31:0] oc_ff, tv_ff, ot_ff;
   logic signed [31:0] nv_ff, res_ff;
   logic signed [31:0] pa, pb;
   logic signed [63:0] pp, pq;
   logic signed [31:0] pm;
   logic signed [32:0] diff, lim, chg;
   logic signed [33:0] rr;
   logic ovr;

   assign pp = pa * pb;
   // truncate toward zero
   assign pq = (pp < 0) ? -((-pp) >>> FRAC_BITS) : (pp >>> FRAC_BITS);
   assign pm = sat32({{2{pq[63]}}, pq});

   always_comb begin
      pa = coef.omega;
      pb = change_ff;
      case (ps_ff)
         P1: begin pa = sat32(66'(vel_ff) + 66'(oc_ff)); pb = coef.dt; end
         P2: begin pa = coef.omega; pb = tv_ff; end
         P3: begin pa = sat32(66'(vel_ff) - 66'(ot_ff)); pb = coef.decay; end
         P4: begin pa = sat32(66'(change_ff) + 66'(tv_ff)); pb = coef.decay; end
         default: ;
      endcase
   end

   always_comb begin
      diff = 33'(cur) - 33'(tgt);
      lim = {1'b0, coef.limit};
      chg = diff;
      if (diff > lim) chg = lim;
      if (diff < -lim) chg = -lim;
   end

   // adj + product, exact
   assign rr = 34'(cur) - 34'(change_ff) + 34'(pm);
   assign ovr = ((34'(tgt) - 34'(cur)) > 0) == (rr > 34'(tgt));

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= PD;
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         // done pulses the cycle after the last product
         fin_ff <= busy_ff && (ps_ff == P4);
         if (start) begin
            change_ff <= chg[31:0];
            vel_ff <= vel;
            ps_ff <= P0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            case (ps_ff)
               P0: begin oc_ff <= pm; ps_ff <= P1; end
               P1: begin tv_ff <= pm; ps_ff <= P2; end
               P2: begin ot_ff <= pm; ps_ff <= P3; end
               P3: begin nv_ff <= pm; ps_ff <= P4; end
               P4: begin
                  if (ovr) begin
                     res_ff <= tgt;
                     nv_ff <= '0;
                  end else begin
                     res_ff <= sat32(66'(rr));
                  end
                  ps_ff <= PD;
                  busy_ff <= 1'b0;
               end
               default: ps_ff <= PD;
            endcase
         end
      end
   end

   assign done = fin_ff;
   assign res = res_ff;
   assign new_vel = nv_ff;
endmodule

// ===== hdl/critically_damped_smoother.sv =====
// sequence: a word is taken, then come two serial divisions of 34 quotient
// steps, five shared products, then five products in each axis lane; a short
// step answers the cycle after it is taken
// flow: one word at a time; a new word is taken only once the result of the
// last has been taken, so the serial divider and the product sequence set the pace
// reset: synchronous, active high; velocities clear to zero, smooth_time to
// 6554 and max_speed to all ones
// ----------------------------------------------------------------------------
// critically_damped_smoother
// two-axis smooth damp step in signed fixed point
// ----------------------------------------------------------------------------
module critically_damped_smoother #(
   parameter int unsigned FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   cds_req_if.sink   req,
   cds_rsp_if.source rsp,
   cds_csr_if.sink   csr
);
   import cds_pkg::*;

   localparam int unsigned NUM_W = 2 * FRAC_BITS + 2;
   localparam int unsigned DEN_W = 34;
   localparam logic [31:0] MIN_SMOOTH = 32'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] K048 = 32'((48 * (64'd1 << FRAC_BITS) + 50) / 100);
   localparam logic signed [31:0] K0235 = 32'((235 * (64'd1 << FRAC_BITS) + 500) / 1000);

   typedef enum logic [3:0] {
      S_IDLE, S_OMDIV, S_X, S_X2, S_X3, S_T2, S_T3, S_LIM, S_EDIV, S_LANE, S_OUT
   } state_type;

   state_type st_ff;
   logic [31:0] smooth_ff, maxspd_ff;
   logic signed [31:0] velx_ff, vely_ff;
   logic signed [31:0] cx_ff, cy_ff, tx_ff, ty_ff;
   logic [31:0] smooth_eff_ff;
   coef_type coef_ff;
   logic signed [31:0] x_ff, x2_ff, x3_ff, t2_ff;
   logic signed [33:0] den_ff;
   logic rv_ff;
   logic signed [31:0] rx_ff, ry_ff, sx_ff, sy_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= 32'd6554;
         maxspd_ff <= 32'hFFFFFFFF;
      end else if (csr.valid && csr.index[31:CSR_IDX_W] == '0) begin
         unique case (csr_index_type'(csr.index[CSR_IDX_W-1:0]))
            CSR_SMOOTH_TIME: smooth_ff <= csr.data;
            CSR_MAX_SPEED:   maxspd_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // shared divider
   logic div_start, div_done;
   logic [NUM_W-1:0] div_num, div_q;
   logic [DEN_W-1:0] div_den;
   cds_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(div_den), .done(div_done), .quot(div_q)
   );

   // shared coefficient multiplier
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod, qt;
   logic signed [31:0] mq;
   assign prod = ma * mb;
   assign qt = (prod < 0) ? -((-prod) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
   assign mq = sat32({{2{qt[63]}}, qt});
   logic [63:0] lprod;
   assign lprod = 64'(maxspd_ff) * 64'(smooth_eff_ff);

   always_comb begin
      ma = coef_ff.omega; mb = coef_ff.dt;
      case (st_ff)
         S_X2: begin ma = x_ff; mb = x_ff; end
         S_X3: begin ma = x2_ff; mb = x_ff; end
         S_T2: begin ma = K048; mb = x2_ff; end
         S_T3: begin ma = K0235; mb = x3_ff; end
         default: ;
      endcase
   end

   logic lane_start, lx_done, ly_done;
   logic signed [31:0] lrx, lry, lvx, lvy;
   cds_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock(clock), .reset(reset), .start(lane_start), .coef(coef_ff),
      .cur(cx_ff), .tgt(tx_ff), .vel(velx_ff), .done(lx_done), .res(lrx), .new_vel(lvx)
   );
   cds_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock(clock), .reset(reset), .start(lane_start), .coef(coef_ff),
      .cur(cy_ff), .tgt(ty_ff), .vel(vely_ff), .done(ly_done), .res(lry), .new_vel(lvy)
   );

   logic lane_go_ff;
   assign lane_start = lane_go_ff;

   assign req.ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.result_x = rx_ff;
   assign rsp.result_y = ry_ff;
   assign rsp.speed_x = sx_ff;
   assign rsp.speed_y = sy_ff;

   always_comb begin
      div_start = 1'b0;
      div_num = NUM_W'(2) << (2 * FRAC_BITS);
      div_den = DEN_W'(smooth_eff_ff);
      if (st_ff == S_IDLE && req.valid && req.ready && req.step_time >= STEP_MIN) begin
         div_start = 1'b1;
         div_den = DEN_W'((smooth_ff < MIN_SMOOTH) ? MIN_SMOOTH : smooth_ff);
      end else if (st_ff == S_LIM) begin
         div_start = 1'b1;
         div_num = NUM_W'(1) << (2 * FRAC_BITS);
         div_den = den_ff[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         velx_ff <= '0;
         vely_ff <= '0;
         lane_go_ff <= 1'b0;
      end else begin
         lane_go_ff <= (st_ff == S_EDIV) && div_done;
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req.valid && req.ready) begin
               cx_ff <= req.current_x; cy_ff <= req.current_y;
               tx_ff <= req.target_x;  ty_ff <= req.target_y;
               coef_ff.dt <= 32'((64'(req.step_time) << FRAC_BITS) >> 16);
               smooth_eff_ff <= (smooth_ff < MIN_SMOOTH) ? MIN_SMOOTH : smooth_ff;
               if (req.step_time < STEP_MIN) begin
                  rx_ff <= req.current_x; ry_ff <= req.current_y;
                  sx_ff <= velx_ff; sy_ff <= vely_ff;
                  rv_ff <= 1'b1;
               end else st_ff <= S_OMDIV;
            end
            S_OMDIV: if (div_done) begin
               coef_ff.omega <= (div_q > NUM_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF :
                                32'(div_q);
               st_ff <= S_X;
            end
            S_X:  begin x_ff <= mq; st_ff <= S_X2; end
            S_X2: begin x2_ff <= mq; st_ff <= S_X3; end
            S_X3: begin x3_ff <= mq; st_ff <= S_T2; end
            S_T2: begin t2_ff <= mq; st_ff <= S_T3; end
            S_T3: begin
               den_ff <= 34'(ONE_Q) + 34'(x_ff) + 34'(t2_ff) + 34'(mq);
               coef_ff.limit <= (lprod[63:FRAC_BITS] > (64-FRAC_BITS)'(32'h7FFFFFFF)) ?
                                32'sh7FFFFFFF : 32'(lprod[63:FRAC_BITS]);
               st_ff <= S_LIM;
            end
            S_LIM: st_ff <= S_EDIV;
            S_EDIV: if (div_done) begin
               coef_ff.decay <= 32'(div_q);
               st_ff <= S_LANE;
            end
            S_LANE: if (lx_done && ly_done) st_ff <= S_OUT;
            S_OUT: begin
               rx_ff <= lrx; ry_ff <= lry;
               sx_ff <= lvx; sy_ff <= lvy;
               velx_ff <= lvx; vely_ff <= lvy;
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_x))
      else $error("result dropped under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !req.ready)
      else $error("input taken while busy");
   a_vel_stable: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_OUT |=> $stable(velx_ff) && $stable(vely_ff))
      else $error("velocity changed outside update");
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the critically damped smoother: random and directed
// position words, register settings between phases, bit-exact prediction
// ----------------------------------------------------------------------------
module tb_top;
   import cds_pkg::*;

   localparam int FB = 16;
   localparam longint ONE_Q = 64'sd1 << FB;
   localparam longint MIN_ST = ((64'd1 << FB) + 9999) / 10000;
   localparam longint K048 = (48 * ONE_Q + 50) / 100;
   localparam longint K0235 = (235 * ONE_Q + 500) / 1000;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic [15:0] st;
   } step_word_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } smooth_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cds_req_if req ();
   cds_rsp_if rsp ();
   cds_csr_if csr ();

   critically_damped_smoother u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [31:0] p_smooth = 32'd6554;
   logic [31:0] p_speed = 32'hFFFFFFFF;
   logic signed [31:0] p_vx = 0;
   logic signed [31:0] p_vy = 0;

   step_word_type pending_q[$];
   smooth_word_type expected_q[$];
   int errors = 0;
   int n_in = 0;
   int n_out = 0;
   bit quiet = 0;
   bit hold_go = 0;
   bit hold_off = 0;

   function automatic longint clamp32(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clamp32((a * b) / ONE_Q);
   endfunction

   function automatic void damp_axis(input longint cur, input longint tgt,
                                     inout logic signed [31:0] vel,
                                     input longint om, input longint e,
                                     input longint dt, input longint lim,
                                     output longint res);
      longint ch, adj, v, tmp, nv;
      ch = cur - tgt;
      if (ch > lim) ch = lim;
      if (ch < -lim) ch = -lim;
      adj = cur - ch;
      v = vel;
      tmp = qmul(clamp32(v + qmul(om, ch)), dt);
      nv = qmul(clamp32(v - qmul(om, tmp)), e);
      res = adj + qmul(clamp32(ch + tmp), e);
      if ((tgt - cur > 0) == (res > tgt)) begin
         res = tgt;
         nv = 0;
      end
      vel = 32'(clamp32(nv));
      res = clamp32(res);
   endfunction

   function automatic smooth_word_type smooth_step(step_word_type w);
      smooth_word_type r;
      longint rx, ry, dt, om, x, x2, x3, den, e, lim;
      longint unsigned st, mc, uom;
      if (w.st < STEP_MIN) begin
         rx = w.cx;
         ry = w.cy;
      end else begin
         st = p_smooth;
         if (st < MIN_ST) st = MIN_ST;
         dt = (longint'(w.st) << FB) >> 16;
         uom = (64'd2 << (2 * FB)) / st;
         om = (uom > SMAX) ? SMAX : longint'(uom);
         x = qmul(om, dt);
         x2 = qmul(x, x);
         x3 = qmul(x2, x);
         den = ONE_Q + x + qmul(K048, x2) + qmul(K0235, x3);
         e = (64'sd1 << (2 * FB)) / den;
         mc = (longint'(p_speed) * st) >> FB;
         lim = (mc > SMAX) ? SMAX : longint'(mc);
         damp_axis(w.cx, w.tx, p_vx, om, e, dt, lim, rx);
         damp_axis(w.cy, w.ty, p_vy, om, e, dt, lim, ry);
      end
      r.rx = 32'(rx);
      r.ry = 32'(ry);
      r.vx = p_vx;
      r.vy = p_vy;
      return r;
   endfunction

   // driver
   initial begin
      req.valid = 0;
      req.current_x = 0; req.current_y = 0; req.target_x = 0; req.target_y = 0;
      req.step_time = 0;
      csr.valid = 0; csr.index = 0; csr.data = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_q.push_back(smooth_step({req.current_x, req.current_y,
               req.target_x, req.target_y, req.step_time}));
            n_in++;
         end
         if ((!req.valid || req.ready)) begin
            if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
               step_word_type w;
               w = pending_q.pop_front();
               req.valid <= 1'b1;
               req.current_x <= w.cx; req.current_y <= w.cy;
               req.target_x <= w.tx; req.target_y <= w.ty;
               req.step_time <= w.st;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   initial rsp.ready = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            smooth_word_type got, exp_w;
            got = {rsp.result_x, rsp.result_y, rsp.speed_x, rsp.speed_y};
            n_out++;
            if (expected_q.size() == 0) begin
               $display("%0t unexpected word %h", $time, got);
               errors++;
            end else begin
               exp_w = expected_q.pop_front();
               if (got.rx !== exp_w.rx)
                  $display("%0t result_x exp %h got %h", $time, exp_w.rx, got.rx);
               if (got.ry !== exp_w.ry)
                  $display("%0t result_y exp %h got %h", $time, exp_w.ry, got.ry);
               if (got.vx !== exp_w.vx)
                  $display("%0t speed_x exp %h got %h", $time, exp_w.vx, got.vx);
               if (got.vy !== exp_w.vy)
                  $display("%0t speed_y exp %h got %h", $time, exp_w.vy, got.vy);
               if (got !== exp_w) errors++;
            end
         end
         if (hold_off) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= quiet || ($urandom_range(99) >= 28);
         end
      end
   end

   // long receiver hold-off, counted here in cycles
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (2000) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= 32'(idx);
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == CSR_SMOOTH_TIME) p_smooth = val;
      else p_speed = val;
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_pos(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(65536 * 200) - 65536 * 100;
         default: return $urandom_range(4096) - 2048;
      endcase
   endfunction

   task automatic add_random(int n);
      step_word_type w;
      int m;
      repeat (n) begin
         m = $urandom_range(9) == 0 ? 0 : $urandom_range(2) + 0;
         if (m == 0 && $urandom_range(1)) m = 1;
         w.cx = rnd_pos(m); w.cy = rnd_pos(m);
         w.tx = rnd_pos(m); w.ty = rnd_pos(m);
         case ($urandom_range(9))
            0: w.st = 16'($urandom_range(65));
            1: w.st = 16'($urandom);
            default: w.st = 16'($urandom_range(2000, 66));
         endcase
         pending_q.push_back(w);
      end
   endtask

   logic [31:0] st_set[6] = '{32'd6554, 32'd7, 32'hFFFFFFFF, 32'd65536, 32'd3, 32'd800};
   logic [31:0] ms_set[6] = '{32'hFFFFFFFF, 32'd0, 32'd65536, 32'h00A00000, 32'd1, 32'd12345};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed words: extremes, short step edge, overshoot
      pending_q.push_back({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                           16'hFFFF});
      pending_q.push_back({32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                           16'd66});
      pending_q.push_back({32'sd100, 32'sd100, 32'sd100, 32'sd100, 16'd65});
      pending_q.push_back({32'sd0, 32'sd0, 32'sd65536, -32'sd65536, 16'd0});
      pending_q.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 16'd1000});
      pending_q.push_back({32'sd0, 32'sd0, 32'sd1, -32'sd1, 16'd40000});
      pending_q.push_back({32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'h0, 16'hAAAA});
      pending_q.push_back({32'h55555555, 32'h0, 32'hAAAAAAAA, 32'hFFFFFFFF, 16'h5555});
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_SMOOTH_TIME, st_set[ph]);
         csr_write(CSR_MAX_SPEED, ms_set[ph]);
         if (ph == 2) begin
            quiet = 1;
            add_random(40);
            drain();
            quiet = 0;
         end
         if (ph == 3) begin
            // receiver held off while the sender keeps offering words
            add_random(30);
            hold_go = 1;
            drain();
         end
         add_random(100);
         drain();
      end
      $display("covered %0d words in, %0d words out, over six register settings",
               n_in, n_out);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
